// ----- sv/bbhk_pkg.sv -----
// Package for the bounded best hits keeper: payload types and constants.
// No dependencies.
package bbhk_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int MOTIF_BASES_DEF = 32;
    localparam logic [6:0] MAX_HITS_RESET = 7'd16;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DUMP   = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] hit_score;
        logic [63:0]        hit_bases;
        logic [15:0]        source_id;
        logic [31:0]        position;
        logic               reverse_strand;
    } in_item_t;

    typedef struct packed {
        logic               entry_valid;
        logic signed [31:0] out_score;
        logic [63:0]        out_bases;
        logic [15:0]        out_source;
        logic [31:0]        out_position;
        logic               out_reverse;
        logic               table_full;
        logic               last;
    } out_item_t;

endpackage

// ----- sv/bbhk_front.sv -----
// Front end: accepts input beats, masks and reverse complements bases,
// pushes classified items into a two-entry queue. Depends on bbhk_pkg.
module bbhk_front #(
    parameter int MOTIF_BASES = bbhk_pkg::MOTIF_BASES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  bbhk_pkg::in_item_t   in_data,
    output logic                 q_valid,
    input  logic                 q_pop,
    output bbhk_pkg::in_item_t   q_data
);
    localparam int NB = 2 * MOTIF_BASES;

    bbhk_pkg::in_item_t q_mem_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    logic       push;
    bbhk_pkg::in_item_t conv;
    logic [63:0] rc;

    always_comb
    begin
        rc = '0;
        for (int i = 0; i < MOTIF_BASES; i++)
        begin
            rc[2*i +: 2] = 2'd3 - in_data.hit_bases[2*(MOTIF_BASES-1-i) +: 2];
        end
        conv = in_data;
        conv.hit_bases = '0;
        conv.hit_bases[NB-1:0] = in_data.reverse_strand ? rc[NB-1:0]
                                                        : in_data.hit_bases[NB-1:0];
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = q_mem_reg[rp_reg];
    assign cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop && q_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wp_reg <= ~wp_reg;
            if (q_pop && q_valid)
                rp_reg <= ~rp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wp_reg] <= conv;
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> in_stall)
        else $error("full queue not stalling");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 && !in_valid) |=> !q_valid)
        else $error("queue invented an item");
endmodule

// ----- sv/bbhk_back.sv -----
// Back end: sorted hit table as a shift array, one shift step per cycle,
// plus dump streaming into an output register. Depends on bbhk_pkg.
module bbhk_back #(
    parameter int TABLE_DEPTH = bbhk_pkg::TABLE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [6:0]          max_hits,
    input  logic                q_valid,
    output logic                q_pop,
    input  bbhk_pkg::in_item_t  q_data,
    output logic                out_valid,
    input  logic                out_stall,
    output bbhk_pkg::out_item_t out_data
);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [1:0] ST_IDLE = 2'd0, ST_SCAN = 2'd1, ST_DROP = 2'd2,
                           ST_DUMP = 2'd3;

    logic signed [31:0] sc_reg [TABLE_DEPTH];
    logic [63:0] ba_reg [TABLE_DEPTH];
    logic [15:0] so_reg [TABLE_DEPTH];
    logic [31:0] po_reg [TABLE_DEPTH];
    logic        rv_reg [TABLE_DEPTH];

    logic [1:0]    st_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] idx_reg;   // scan position, walks back to front
    logic [CW-1:0] slot_reg;  // where the new hit lands after a front drop
    logic          full_reg;
    logic          ov_reg;
    bbhk_pkg::out_item_t od_reg;
    logic [CW-1:0] limit;
    logic          overflow;
    logic          out_free;
    logic          place;     // new item goes at idx_reg
    logic [IW-1:0] ix;
    logic [IW-1:0] ixn;

    assign limit = (max_hits > 7'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(max_hits);
    assign overflow = (cnt_reg >= limit);
    assign out_free = !ov_reg || !out_stall;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign ix  = IW'(idx_reg - CW'(1));
    assign ixn = IW'(idx_reg + CW'(1));
    // walking from back: place at idx when idx==0 or entry idx-1 scores > new
    assign place = (idx_reg == '0) || (sc_reg[ix] > q_data.hit_score);
    assign q_pop = ((st_reg == ST_SCAN) && place && (!overflow || idx_reg == '0))
                || ((st_reg == ST_DROP) && idx_reg == slot_reg)
                || ((st_reg == ST_DUMP) && out_free &&
                    (cnt_reg == '0 || idx_reg == cnt_reg - CW'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            cnt_reg  <= '0;
            idx_reg  <= '0;
            slot_reg <= '0;
            full_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (st_reg == ST_DUMP && out_free)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
            case (st_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_data.cmd == bbhk_pkg::CMD_DUMP)
                        begin
                            st_reg  <= ST_DUMP;
                            idx_reg <= '0;
                        end
                        else
                        begin
                            st_reg  <= ST_SCAN;
                            idx_reg <= cnt_reg;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (place)
                    begin
                        if (overflow)
                        begin
                            full_reg <= 1'b1;
                            // a hit that would sit at the front is dropped itself
                            if (idx_reg == '0)
                                st_reg <= ST_IDLE;
                            else
                            begin
                                st_reg   <= ST_DROP;
                                slot_reg <= idx_reg - CW'(1);
                                idx_reg  <= '0;
                            end
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + CW'(1);
                            st_reg  <= ST_IDLE;
                        end
                    end
                    else
                        idx_reg <= idx_reg - CW'(1);
                end
                ST_DROP:
                begin
                    if (idx_reg == slot_reg)
                        st_reg <= ST_IDLE;
                    else
                        idx_reg <= idx_reg + CW'(1);
                end
                ST_DUMP:
                begin
                    if (out_free)
                    begin
                        if (cnt_reg == '0 || idx_reg == cnt_reg - CW'(1))
                            st_reg <= ST_IDLE;
                        else
                            idx_reg <= idx_reg + CW'(1);
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    // Normal insert shifts entries back while walking. On overflow the walk
    // only finds the slot; entries ahead of it then move one toward the front
    // over the old front entry, and the new hit fills the freed slot.
    always_ff @(posedge clk)
    begin
        if (st_reg == ST_SCAN && !overflow)
        begin
            if (place)
            begin
                sc_reg[IW'(idx_reg)] <= q_data.hit_score;
                ba_reg[IW'(idx_reg)] <= q_data.hit_bases;
                so_reg[IW'(idx_reg)] <= q_data.source_id;
                po_reg[IW'(idx_reg)] <= q_data.position;
                rv_reg[IW'(idx_reg)] <= q_data.reverse_strand;
            end
            else
            begin
                sc_reg[IW'(idx_reg)] <= sc_reg[ix];
                ba_reg[IW'(idx_reg)] <= ba_reg[ix];
                so_reg[IW'(idx_reg)] <= so_reg[ix];
                po_reg[IW'(idx_reg)] <= po_reg[ix];
                rv_reg[IW'(idx_reg)] <= rv_reg[ix];
            end
        end
        if (st_reg == ST_DROP)
        begin
            if (idx_reg == slot_reg)
            begin
                sc_reg[IW'(idx_reg)] <= q_data.hit_score;
                ba_reg[IW'(idx_reg)] <= q_data.hit_bases;
                so_reg[IW'(idx_reg)] <= q_data.source_id;
                po_reg[IW'(idx_reg)] <= q_data.position;
                rv_reg[IW'(idx_reg)] <= q_data.reverse_strand;
            end
            else
            begin
                sc_reg[IW'(idx_reg)] <= sc_reg[ixn];
                ba_reg[IW'(idx_reg)] <= ba_reg[ixn];
                so_reg[IW'(idx_reg)] <= so_reg[ixn];
                po_reg[IW'(idx_reg)] <= po_reg[ixn];
                rv_reg[IW'(idx_reg)] <= rv_reg[ixn];
            end
        end
        if (st_reg == ST_DUMP && out_free)
        begin
            od_reg.entry_valid  <= (cnt_reg != '0);
            od_reg.out_score    <= (cnt_reg != '0) ? sc_reg[IW'(idx_reg)] : '0;
            od_reg.out_bases    <= (cnt_reg != '0) ? ba_reg[IW'(idx_reg)] : '0;
            od_reg.out_source   <= (cnt_reg != '0) ? so_reg[IW'(idx_reg)] : '0;
            od_reg.out_position <= (cnt_reg != '0) ? po_reg[IW'(idx_reg)] : '0;
            od_reg.out_reverse  <= (cnt_reg != '0) ? rv_reg[IW'(idx_reg)] : 1'b0;
            od_reg.table_full   <= full_reg;
            od_reg.last <= (cnt_reg == '0) || (idx_reg == cnt_reg - CW'(1));
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CW'(TABLE_DEPTH))
        else $error("entry count past depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full_reg) |-> $past(st_reg) == ST_SCAN)
        else $error("full flag set outside insert");
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_DUMP) |-> (cnt_reg == '0 || idx_reg < cnt_reg))
        else $error("dump index out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_DROP) |-> (idx_reg <= slot_reg))
        else $error("drop pass past its slot");
endmodule

// ----- sv/bounded_best_hits_keeper_unit.sv -----
// Bounded best hits keeper: top level joining front end and table back end.
// Depends on bbhk_pkg, bbhk_front, bbhk_back.
//
// Usage: input beats on in_valid/in_stall/in_data. An insert beat (cmd 0)
// places the hit into a table sorted highest score first, keeping the
// max_hits lowest, capped at TABLE_DEPTH; a dump beat (cmd 1) streams
// every entry front to back on out_valid/out_stall/out_data, last marking
// the final beat; an empty table gives one beat with entry_valid 0. The user
// writes max_hits with cfg_we/cfg_data while idle; the block does not check.
// Rate: an insert walks the shift array from the last entry back to its
// slot; when the table overflows, a pass over the entries ahead of the
// slot follows. A dump beat moves the back end from idle into its dump
// state, which loads the output register, one beat per cycle while the
// receiver does not stall. The two-entry queue lets the front take beats
// while the back end works or the receiver stalls; a stall holds the output
// register and the dump pauses. Reset empties the table, clears the full
// flag and sets max_hits to 16.
module bounded_best_hits_keeper_unit #(
    parameter int TABLE_DEPTH = bbhk_pkg::TABLE_DEPTH_DEF,
    parameter int MOTIF_BASES = bbhk_pkg::MOTIF_BASES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  bbhk_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output bbhk_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [6:0]          cfg_data
);
    logic [6:0] max_hits_reg;
    logic q_valid, q_pop;
    bbhk_pkg::in_item_t q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_hits_reg <= bbhk_pkg::MAX_HITS_RESET;
        else if (cfg_we)
            max_hits_reg <= cfg_data;
    end

    bbhk_front #(.MOTIF_BASES(MOTIF_BASES)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_data(in_data), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
    );

    bbhk_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .max_hits(max_hits_reg), .q_valid(q_valid),
        .q_pop(q_pop), .q_data(q_data), .out_valid(out_valid),
        .out_stall(out_stall), .out_data(out_data)
    );
endmodule
